[sv/iph_pkg.sv]
package iph_pkg;

  localparam int HIST_DEPTH = 64;
  localparam int PTR_W      = $clog2(HIST_DEPTH);
  localparam int CNT_W      = $clog2(HIST_DEPTH + 1);

  localparam int TIME_W  = 48;
  localparam int PWR_W   = 32;
  localparam int SUM_W   = 40;
  localparam int LEN_W   = 32;
  localparam int PCNT_W  = 8;
  localparam int FRAC_W  = 17;
  localparam int COLL_W  = 9;
  localparam int ACC_W   = SUM_W + TIME_W + CNT_W;
  localparam int CSUM_W  = CNT_W + PCNT_W + 1;
  localparam int DIV_CW  = $clog2(SUM_W + 1);

  localparam logic [2:0] ACT_ADD     = 3'd0;
  localparam logic [2:0] ACT_REMOVE  = 3'd1;
  localparam logic [2:0] ACT_INTERF  = 3'd2;
  localparam logic [2:0] ACT_OVERLAP = 3'd3;
  localparam logic [2:0] ACT_COUNTS  = 3'd4;
  localparam logic [2:0] ACT_TOTAL   = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_DROP  = 2'd2;
  localparam logic [1:0] ST_UNDER = 2'd3;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_REMOVE,
    OP_INTERF,
    OP_OVERLAP,
    OP_COUNTS,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [TIME_W-1:0] now;
    logic [PWR_W-1:0]  pw;
    logic              ctrl;
    logic [TIME_W-1:0] start;
    logic [LEN_W-1:0]  len;
  } cmd_t;

  function automatic logic [PTR_W-1:0] slot_of(logic [PTR_W-1:0] base,
                                                logic [CNT_W-1:0] ofs);
    logic [CNT_W:0] s;
    s = {{(CNT_W + 1 - PTR_W){1'b0}}, base} + {1'b0, ofs};
    if (s >= (CNT_W + 1)'(HIST_DEPTH)) s = s - (CNT_W + 1)'(HIST_DEPTH);
    return s[PTR_W-1:0];
  endfunction

endpackage

[sv/iph_if.sv]
interface iph_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [47:0] now_time;
  logic [31:0] signal_power;
  logic        is_control;
  logic [47:0] window_start;
  logic [31:0] window_length;

  modport source (output valid, action, now_time, signal_power, is_control,
                  window_start, window_length, input ready);
  modport sink (input valid, action, now_time, signal_power, is_control,
                window_start, window_length, output ready);
endinterface

interface iph_out_if;
  logic              valid;
  logic              ready;
  logic [39:0]       interference_level;
  logic [16:0]       overlap_fraction;
  logic signed [8:0] control_collisions;
  logic signed [8:0] data_collisions;
  logic [39:0]       total_power;
  logic [1:0]        status;

  modport source (output valid, interference_level, overlap_fraction,
                  control_collisions, data_collisions, total_power, status,
                  input ready);
  modport sink (input valid, interference_level, overlap_fraction,
                control_collisions, data_collisions, total_power, status,
                output ready);
endinterface

[sv/iph_front.sv]
module iph_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  iph_in_if.sink        in_s,
  output logic          cmd_valid_o,
  output iph_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);

  iph_pkg::cmd_t fifo_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;
  iph_pkg::cmd_t cmd_in;
  logic          push, pop;

  always_comb begin
    cmd_in.now   = in_s.now_time;
    cmd_in.pw    = in_s.signal_power;
    cmd_in.ctrl  = in_s.is_control;
    cmd_in.start = in_s.window_start;
    cmd_in.len   = (in_s.window_length == '0) ? 32'd1 : in_s.window_length;
    case (in_s.action)
      iph_pkg::ACT_ADD:     cmd_in.op = iph_pkg::OP_ADD;
      iph_pkg::ACT_REMOVE:  cmd_in.op = iph_pkg::OP_REMOVE;
      iph_pkg::ACT_INTERF:  cmd_in.op = iph_pkg::OP_INTERF;
      iph_pkg::ACT_OVERLAP: cmd_in.op = iph_pkg::OP_OVERLAP;
      iph_pkg::ACT_COUNTS:  cmd_in.op = iph_pkg::OP_COUNTS;
      iph_pkg::ACT_TOTAL:   cmd_in.op = iph_pkg::OP_NOP;
      default:              cmd_in.op = iph_pkg::OP_NOP;
    endcase
  end

  assign in_s.ready  = (cnt_q != 2'd2);
  assign push        = in_s.valid && in_s.ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= cmd_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[sv/iph_div.sv]
module iph_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [iph_pkg::LEN_W-1:0]  den_i,
  input  logic [iph_pkg::LEN_W-1:0]  rem_i,
  input  logic [iph_pkg::SUM_W-1:0]  num_i,
  input  logic [iph_pkg::DIV_CW-1:0] nbits_i,
  output logic                       done_o,
  output logic [iph_pkg::SUM_W-1:0]  quot_o
);

  logic [iph_pkg::LEN_W-1:0]  den_q, rem_q;
  logic [iph_pkg::SUM_W-1:0]  num_q, quot_q;
  logic [iph_pkg::DIV_CW-1:0] cnt_q;
  logic                       run_q, done_q;
  logic [iph_pkg::LEN_W:0]    trial, diff;
  logic                       ge;

  assign trial = {rem_q, num_q[iph_pkg::SUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
      num_q  <= '0;
      quot_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        den_q  <= den_i;
        rem_q  <= rem_i;
        num_q  <= num_i;
        quot_q <= '0;
        cnt_q  <= nbits_i;
        run_q  <= 1'b1;
      end else if (run_q) begin
        rem_q  <= ge ? diff[iph_pkg::LEN_W-1:0] : trial[iph_pkg::LEN_W-1:0];
        num_q  <= {num_q[iph_pkg::SUM_W-2:0], 1'b0};
        quot_q <= {quot_q[iph_pkg::SUM_W-2:0], ge};
        cnt_q  <= cnt_q - 1'b1;
        if (cnt_q == iph_pkg::DIV_CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

[sv/iph_engine.sv]
module iph_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  iph_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  logic          aging_en_i,
  input  logic [31:0]   max_age_i,
  iph_out_if.source     out_s
);

  typedef enum logic [3:0] {
    S_IDLE, S_AGE_RD, S_AGE_CK, S_APP_RD, S_APP_CK, S_WALK_RD, S_WALK_CK,
    S_MUL0, S_MUL1, S_MUL2, S_DIV_ST, S_DIV, S_POST, S_OUT
  } state_e;

  typedef struct packed {
    logic [iph_pkg::TIME_W-1:0] t;
    logic [iph_pkg::SUM_W-1:0]  sum;
    logic [iph_pkg::PCNT_W-1:0] c;
    logic [iph_pkg::PCNT_W-1:0] d;
  } entry_t;

  localparam int HI_W = iph_pkg::ACC_W - iph_pkg::SUM_W;

  entry_t mem [iph_pkg::HIST_DEPTH];
  entry_t rdata_q, wr_data;
  logic [iph_pkg::PTR_W-1:0] rd_addr, wr_addr;
  logic                      mem_we;

  state_e                      state_q;
  iph_pkg::cmd_t               cmd_q;
  logic [iph_pkg::PTR_W-1:0]   oldest_q;
  logic [iph_pkg::CNT_W-1:0]   count_q, idx_q;
  logic [iph_pkg::SUM_W-1:0]   newest_q, mul_a_q, avg_q, interf_q;
  logic [iph_pkg::TIME_W-1:0]  last_q, mul_b_q, ov_q;
  logic                        first_q, stop_q;
  logic [iph_pkg::ACC_W-1:0]   acc_q;
  logic [63:0]                 prod_q, prod_w;
  logic [23:0]                 mul_part;
  logic [iph_pkg::CSUM_W-1:0]  cc_q, dc_q;
  logic [iph_pkg::PCNT_W-1:0]  lc_q, ld_q;
  logic [iph_pkg::FRAC_W-1:0]  frac_q;
  logic [1:0]                  status_q;

  logic                        out_v_q;
  logic [iph_pkg::SUM_W-1:0]   o_interf_q, o_total_q;
  logic [iph_pkg::FRAC_W-1:0]  o_frac_q;
  logic [iph_pkg::COLL_W-1:0]  o_cc_q, o_dc_q;
  logic [1:0]                  o_status_q;

  logic                        age_hit, in_win, full, has, under, coll, stop_w;
  logic [iph_pkg::TIME_W-1:0]  diff;
  logic [iph_pkg::SUM_W-1:0]   base_sum, new_sum;
  logic [iph_pkg::PCNT_W-1:0]  base_c, base_d, new_c, new_d;
  logic [iph_pkg::SUM_W:0]     sum_ext;
  logic [HI_W-1:0]             acc_hi;
  logic                        div_start, div_done, int_sat;
  logic [iph_pkg::LEN_W-1:0]   div_rem;
  logic [iph_pkg::SUM_W-1:0]   div_num, div_quot;
  logic [iph_pkg::DIV_CW-1:0]  div_nbits;

  function automatic logic [iph_pkg::COLL_W-1:0] clamp_cnt(
      logic [iph_pkg::CSUM_W-1:0] v, logic own);
    logic [iph_pkg::CSUM_W:0] w;
    w = {1'b0, v} - {{iph_pkg::CSUM_W{1'b0}}, own};
    if (w[iph_pkg::CSUM_W]) return '1;
    else if (w > (iph_pkg::CSUM_W + 1)'(255)) return iph_pkg::COLL_W'(255);
    else return w[iph_pkg::COLL_W-1:0];
  endfunction

  // memory
  always_comb begin
    case (state_q)
      S_APP_RD:  rd_addr = iph_pkg::slot_of(oldest_q, count_q - 1'b1);
      S_WALK_RD: rd_addr = iph_pkg::slot_of(oldest_q, idx_q - 1'b1);
      default:   rd_addr = oldest_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rdata_q <= mem[rd_addr];
  end

  // append datapath
  assign has      = (count_q != '0);
  assign full     = (count_q == iph_pkg::CNT_W'(iph_pkg::HIST_DEPTH));
  assign base_sum = has ? rdata_q.sum : '0;
  assign base_c   = has ? rdata_q.c : '0;
  assign base_d   = has ? rdata_q.d : '0;
  assign sum_ext  = {1'b0, base_sum} + {9'b0, cmd_q.pw};

  always_comb begin
    new_c = base_c;
    new_d = base_d;
    under = 1'b0;
    if (cmd_q.op == iph_pkg::OP_ADD) begin
      new_sum = sum_ext[iph_pkg::SUM_W] ? '1 : sum_ext[iph_pkg::SUM_W-1:0];
      if (cmd_q.ctrl) begin
        if (base_c != '1) new_c = base_c + 1'b1;
      end else begin
        if (base_d != '1) new_d = base_d + 1'b1;
      end
    end else begin
      new_sum = (base_sum > {8'b0, cmd_q.pw}) ? base_sum - {8'b0, cmd_q.pw} : '0;
      if (cmd_q.ctrl) begin
        if (base_c != '0) new_c = base_c - 1'b1;
        else under = 1'b1;
      end else begin
        if (base_d != '0) new_d = base_d - 1'b1;
        else under = 1'b1;
      end
    end
  end

  assign mem_we  = (state_q == S_APP_CK);
  assign wr_addr = full ? oldest_q : iph_pkg::slot_of(oldest_q, count_q);
  assign wr_data = '{t: cmd_q.now, sum: new_sum, c: new_c, d: new_d};

  // walk datapath
  assign age_hit = ({1'b0, rdata_q.t} + 49'(max_age_i)) < {1'b0, cmd_q.now};
  assign in_win  = cmd_q.start < rdata_q.t;
  always_comb begin
    if (in_win) diff = (last_q > rdata_q.t) ? last_q - rdata_q.t : '0;
    else        diff = (last_q > cmd_q.start) ? last_q - cmd_q.start : '0;
  end
  assign coll   = (rdata_q.c > 8'd1) || (rdata_q.d > 8'd1);
  assign stop_w = !in_win || (idx_q == iph_pkg::CNT_W'(1));

  assign mul_part = (state_q == S_MUL0) ? mul_b_q[23:0] : mul_b_q[47:24];
  assign prod_w   = {24'b0, mul_a_q} * {40'b0, mul_part};

  // divider hookup
  assign acc_hi  = acc_q[iph_pkg::ACC_W-1:iph_pkg::SUM_W];
  assign int_sat = (cmd_q.op == iph_pkg::OP_INTERF) ?
                   (acc_hi >= HI_W'(cmd_q.len)) :
                   (ov_q >= iph_pkg::TIME_W'(cmd_q.len));
  assign div_start = (state_q == S_DIV_ST) && !int_sat;
  always_comb begin
    if (cmd_q.op == iph_pkg::OP_INTERF) begin
      div_rem   = acc_hi[iph_pkg::LEN_W-1:0];
      div_num   = acc_q[iph_pkg::SUM_W-1:0];
      div_nbits = iph_pkg::DIV_CW'(iph_pkg::SUM_W);
    end else begin
      div_rem   = ov_q[iph_pkg::LEN_W-1:0];
      div_num   = '0;
      div_nbits = iph_pkg::DIV_CW'(16);
    end
  end

  iph_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .den_i   (cmd_q.len),
    .rem_i   (div_rem),
    .num_i   (div_num),
    .nbits_i (div_nbits),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cmd_q      <= '0;
      oldest_q   <= '0;
      count_q    <= '0;
      newest_q   <= '0;
      idx_q      <= '0;
      last_q     <= '0;
      first_q    <= 1'b0;
      stop_q     <= 1'b0;
      acc_q      <= '0;
      prod_q     <= '0;
      mul_a_q    <= '0;
      mul_b_q    <= '0;
      ov_q       <= '0;
      cc_q       <= '0;
      dc_q       <= '0;
      lc_q       <= '0;
      ld_q       <= '0;
      avg_q      <= '0;
      interf_q   <= '0;
      frac_q     <= '0;
      status_q   <= iph_pkg::ST_OK;
      out_v_q    <= 1'b0;
      o_interf_q <= '0;
      o_frac_q   <= '0;
      o_cc_q     <= '0;
      o_dc_q     <= '0;
      o_total_q  <= '0;
      o_status_q <= iph_pkg::ST_OK;
    end else begin
      if (out_s.ready && state_q != S_OUT) out_v_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q    <= cmd_i;
            idx_q    <= count_q;
            last_q   <= cmd_i.now;
            first_q  <= 1'b1;
            acc_q    <= '0;
            ov_q     <= '0;
            cc_q     <= '0;
            dc_q     <= '0;
            interf_q <= '0;
            frac_q   <= '0;
            status_q <= iph_pkg::ST_OK;
            case (cmd_i.op)
              iph_pkg::OP_ADD, iph_pkg::OP_REMOVE: state_q <= S_AGE_RD;
              iph_pkg::OP_INTERF, iph_pkg::OP_OVERLAP, iph_pkg::OP_COUNTS:
                state_q <= has ? S_WALK_RD : S_OUT;
              default: state_q <= S_OUT;
            endcase
          end
        end
        S_AGE_RD: state_q <= (aging_en_i && has) ? S_AGE_CK : S_APP_RD;
        S_AGE_CK: begin
          if (age_hit) begin
            oldest_q <= iph_pkg::slot_of(oldest_q, iph_pkg::CNT_W'(1));
            count_q  <= count_q - 1'b1;
            state_q  <= S_AGE_RD;
          end else begin
            state_q <= S_APP_RD;
          end
        end
        S_APP_RD: begin
          if (cmd_q.op == iph_pkg::OP_REMOVE && !has) begin
            status_q <= iph_pkg::ST_EMPTY;
            state_q  <= S_OUT;
          end else begin
            state_q <= S_APP_CK;
          end
        end
        S_APP_CK: begin
          newest_q <= new_sum;
          if (full) oldest_q <= iph_pkg::slot_of(oldest_q, iph_pkg::CNT_W'(1));
          else count_q <= count_q + 1'b1;
          status_q <= under ? iph_pkg::ST_UNDER : (full ? iph_pkg::ST_DROP : iph_pkg::ST_OK);
          state_q  <= S_OUT;
        end
        S_WALK_RD: state_q <= S_WALK_CK;
        S_WALK_CK: begin
          idx_q <= idx_q - 1'b1;
          if (in_win) last_q <= rdata_q.t;
          case (cmd_q.op)
            iph_pkg::OP_INTERF: begin
              mul_a_q <= rdata_q.sum;
              mul_b_q <= diff;
              stop_q  <= stop_w;
              state_q <= S_MUL0;
            end
            iph_pkg::OP_OVERLAP: begin
              if (coll) ov_q <= ov_q + diff;
              state_q <= stop_w ? S_DIV_ST : S_WALK_RD;
            end
            default: begin
              lc_q <= rdata_q.c;
              ld_q <= rdata_q.d;
              if (first_q) begin
                first_q <= 1'b0;
                state_q <= (idx_q == iph_pkg::CNT_W'(1)) ? S_OUT : S_WALK_RD;
              end else if (in_win) begin
                if (lc_q >= rdata_q.c)
                  cc_q <= cc_q + iph_pkg::CSUM_W'(lc_q - rdata_q.c);
                if (ld_q >= rdata_q.d)
                  dc_q <= dc_q + iph_pkg::CSUM_W'(ld_q - rdata_q.d);
                state_q <= stop_w ? S_OUT : S_WALK_RD;
              end else begin
                cc_q    <= cc_q + iph_pkg::CSUM_W'(rdata_q.c);
                dc_q    <= dc_q + iph_pkg::CSUM_W'(rdata_q.d);
                state_q <= S_OUT;
              end
            end
          endcase
        end
        S_MUL0: begin
          prod_q  <= prod_w;
          state_q <= S_MUL1;
        end
        S_MUL1: begin
          acc_q   <= acc_q + iph_pkg::ACC_W'(prod_q);
          prod_q  <= prod_w;
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          acc_q   <= acc_q + (iph_pkg::ACC_W'(prod_q) << 24);
          state_q <= stop_q ? S_DIV_ST : S_WALK_RD;
        end
        S_DIV_ST: begin
          if (int_sat) begin
            if (cmd_q.op == iph_pkg::OP_INTERF) begin
              avg_q   <= '1;
              state_q <= S_POST;
            end else begin
              frac_q  <= iph_pkg::FRAC_W'(65536);
              state_q <= S_OUT;
            end
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (cmd_q.op == iph_pkg::OP_INTERF) begin
              avg_q   <= div_quot;
              state_q <= S_POST;
            end else begin
              frac_q  <= {1'b0, div_quot[15:0]};
              state_q <= S_OUT;
            end
          end
        end
        S_POST: begin
          interf_q <= (avg_q > {8'b0, cmd_q.pw}) ? avg_q - {8'b0, cmd_q.pw} : '0;
          state_q  <= S_OUT;
        end
        S_OUT: begin
          if (!out_v_q || out_s.ready) begin
            out_v_q    <= 1'b1;
            o_interf_q <= interf_q;
            o_frac_q   <= frac_q;
            o_status_q <= status_q;
            o_total_q  <= has ? newest_q : '0;
            if (cmd_q.op == iph_pkg::OP_COUNTS) begin
              o_cc_q <= clamp_cnt(cc_q, cmd_q.ctrl);
              o_dc_q <= clamp_cnt(dc_q, !cmd_q.ctrl);
            end else begin
              o_cc_q <= '0;
              o_dc_q <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_s.valid              = out_v_q;
  assign out_s.interference_level = o_interf_q;
  assign out_s.overlap_fraction   = o_frac_q;
  assign out_s.control_collisions = o_cc_q;
  assign out_s.data_collisions    = o_dc_q;
  assign out_s.total_power        = o_total_q;
  assign out_s.status             = o_status_q;

endmodule

[sv/interference_power_history_unit.sv]
// Interference power history unit.
// Input channel in_s carries one item per transfer: an add or remove of a
// packet's power, or a query (interference, overlap, counts, total power).
// Output channel out_s returns exactly one result per item, in order.
// Config writes (cfg_we_i, cfg_idx_i, cfg_data_i) set aging enable (index 0)
// and maximum age (index 1); write only while the unit is idle.
// Items enter a two-deep queue, so up to two are taken while the engine is
// busy. The engine handles one item at a time from a 64-entry history RAM:
//   add/remove: with aging on, drop aged-out entries from the oldest end,
//   then read the newest entry and append (a remove that finds the history
//   empty ends there); counts: walk the entries back from the newest;
//   overlap: the same walk, then a divide; interference: a walk with a
//   two-step multiply per entry, then setup, the divide and the subtract;
//   total power: no walk. A saturated average or fraction skips the divide.
// Each entry walked needs a registered RAM read, and the interference and
// overlap queries share one serial divider. Reset empties the history and
// restores aging on with max age 1000000. When out_s is stalled the result
// is held and the engine waits with the next finished result; the queue
// keeps taking items until it holds two.
module interference_power_history_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  iph_in_if.sink     in_s,
  iph_out_if.source  out_s,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  localparam logic CFG_AGING   = 1'b0;
  localparam logic CFG_MAX_AGE = 1'b1;

  logic          aging_en_q;
  logic [31:0]   max_age_q;
  logic          cmd_valid, cmd_pop;
  iph_pkg::cmd_t cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aging_en_q <= 1'b1;
      max_age_q  <= 32'd1000000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_AGING:   aging_en_q <= cfg_data_i[0];
        CFG_MAX_AGE: max_age_q  <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  iph_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_s        (in_s),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  iph_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .aging_en_i  (aging_en_q),
    .max_age_i   (max_age_q),
    .out_s       (out_s)
  );

`ifndef SYNTHESIS
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid) else $error("command popped from empty queue");

  a_empty_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_s.valid && out_s.status == iph_pkg::ST_EMPTY) |-> out_s.total_power == '0)
    else $error("remove on empty history with nonzero total");

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_s.valid && out_s.overlap_fraction[16]) |-> out_s.overlap_fraction[15:0] == '0)
    else $error("overlap fraction above one");
`endif

endmodule
